FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL. Clock clk and reset rst are taken from
// the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside reset
`define VN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every clock edge, reset included
`define VN_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VN_ASSERT(label, prop, msg)
`define VN_ASSERT_ANY(label, prop, msg)
`endif
`endif

FILE: src/vnorm_pkg.sv
package vnorm_pkg;

  // Unit vector scale: 1.0 is 1 << UNIT_BITS (Q1.14)
  localparam int unsigned UNIT_BITS = 14;
  localparam int          UNIT_ONE  = 1 << UNIT_BITS;
  // Quotient magnitude is at most UNIT_ONE, so one extra bit
  localparam int unsigned QUOT_BITS = UNIT_BITS + 1;
  // Width of every result field
  localparam int unsigned FIELD_W   = 16;

  typedef logic signed [FIELD_W-1:0] unit_t;
  typedef logic        [FIELD_W-1:0] len_t;

endpackage

FILE: src/vnorm_in_if.sv
interface vnorm_in_if #(
  parameter int unsigned COMP_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] x_in;
  logic signed [COMP_WIDTH-1:0] y_in;

  modport source (output valid, x_in, y_in, input ready);
  modport sink (input valid, x_in, y_in, output ready);
endinterface

FILE: src/vnorm_out_if.sv
interface vnorm_out_if
  import vnorm_pkg::*;
();
  logic  valid;
  logic  ready;
  unit_t norm_x;
  unit_t norm_y;
  len_t  length;
  logic  was_zero;

  modport source (output valid, norm_x, norm_y, length, was_zero, input ready);
  modport sink (input valid, norm_x, norm_y, length, was_zero, output ready);
endinterface

FILE: src/vector2_normalize_unit.sv
// Channel   Modport  Beat contents
// vec_in    sink     x_in, y_in      (signed, COMP_WIDTH bits each)
// vec_out   source   norm_x, norm_y  (Q1.14), length (unsigned integer, Q16.0), was_zero
//
// One vector per cycle while vec_out does not stall; the stages are magnitude,
// square and sum stages, one root cell per root bit, QUOT_BITS quotient cells,
// one output stage. Reset clears the stage valid bits and the skid valid bit.
// When vec_out stalls, the last result moves into the skid register and the
// whole pipeline holds until that beat is taken.
`include "assert_macros.svh"

module vector2_normalize_unit
  import vnorm_pkg::*;
#(
  parameter int unsigned COMP_WIDTH = 16
) (
  input logic        clk,
  input logic        rst,
  vnorm_in_if.sink   vec_in,
  vnorm_out_if.source vec_out
);

  localparam int unsigned W       = COMP_WIDTH;
  localparam int unsigned SQ_W    = 2 * W;
  localparam int unsigned NROOT   = W;
  localparam int unsigned NQ      = QUOT_BITS;
  localparam int unsigned SIDE_SQ = 2 * W + 2;
  localparam int unsigned NSTG    = 4 + NROOT + NQ;

  // Stage valid bits and global advance
  logic [NSTG-1:0] vld;
  logic            en;
  logic            skid_v;

  assign en           = !skid_v;
  assign vec_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], vec_in.valid};
    end
  end

  // Magnitude and sign
  logic [W-1:0] mag_x, mag_y;
  logic         sgn_x, sgn_y;

  always_ff @(posedge clk) begin
    if (en) begin
      sgn_x <= vec_in.x_in[W-1];
      sgn_y <= vec_in.y_in[W-1];
      mag_x <= vec_in.x_in[W-1] ? (~vec_in.x_in + 1'b1) : vec_in.x_in;
      mag_y <= vec_in.y_in[W-1] ? (~vec_in.y_in + 1'b1) : vec_in.y_in;
    end
  end

  // Squares
  logic [SQ_W-1:0] sq_x, sq_y;
  logic [W-1:0]    mag_x1, mag_y1;
  logic            sgn_x1, sgn_y1;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x   <= SQ_W'(mag_x) * SQ_W'(mag_x);
      sq_y   <= SQ_W'(mag_y) * SQ_W'(mag_y);
      mag_x1 <= mag_x;
      mag_y1 <= mag_y;
      sgn_x1 <= sgn_x;
      sgn_y1 <= sgn_y;
    end
  end

  // Sum of squares, at most 2^(2W-1)
  logic [SQ_W-1:0]    sum_sq;
  logic [SIDE_SQ-1:0] side_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_sq   <= sq_x + sq_y;
      side_sum <= {sgn_x1, sgn_y1, mag_x1, mag_y1};
    end
  end

  // Square root cells
  logic [NROOT:0][SQ_W-1:0]    rt_rem;
  logic [NROOT:0][SQ_W-1:0]    rt_root;
  logic [NROOT:0][SIDE_SQ-1:0] rt_side;

  assign rt_rem[0]  = sum_sq;
  assign rt_root[0] = '0;
  assign rt_side[0] = side_sum;

  for (genvar i = 0; i < NROOT; i++) begin : g_root
    vnorm_sqrt_cell #(
      .WIDTH  (W),
      .STEP   (NROOT - 1 - i),
      .SIDE_W (SIDE_SQ)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .rem_in  (rt_rem[i]),
      .root_in (rt_root[i]),
      .side_in (rt_side[i]),
      .rem     (rt_rem[i+1]),
      .root    (rt_root[i+1]),
      .side    (rt_side[i+1])
    );
  end

  // Division cells: quotient = mag * 2^UNIT_BITS / length
  logic [NQ:0][1:0][W-1:0]    dv_rem;
  logic [NQ:0][1:0][NQ-1:0]   dv_quot;
  logic [NQ:0][W-1:0]         dv_len;
  logic [NQ:0][1:0]           dv_side;

  assign dv_rem[0][1] = rt_side[NROOT][2*W-1:W];
  assign dv_rem[0][0] = rt_side[NROOT][W-1:0];
  assign dv_quot[0]   = '0;
  assign dv_len[0]    = rt_root[NROOT][W-1:0];
  assign dv_side[0]   = rt_side[NROOT][SIDE_SQ-1:SIDE_SQ-2];

  for (genvar j = 0; j < NQ; j++) begin : g_div
    vnorm_div_cell #(
      .WIDTH  (W),
      .SHIFT  (j != 0),
      .SIDE_W (2)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .rem_in  (dv_rem[j]),
      .quot_in (dv_quot[j]),
      .len_in  (dv_len[j]),
      .side_in (dv_side[j]),
      .rem     (dv_rem[j+1]),
      .quot    (dv_quot[j+1]),
      .len     (dv_len[j+1]),
      .side    (dv_side[j+1])
    );
  end

  // Output stage: sign, zero vector and length field
  unit_t qx, qy;
  logic  len_zero;
  unit_t res_x, res_y;
  len_t  res_len;
  logic  res_zero;

  always_comb begin
    len_zero = (dv_len[NQ] == '0);
    qx       = unit_t'(dv_quot[NQ][1]);
    qy       = unit_t'(dv_quot[NQ][0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x    <= len_zero ? '0 : (dv_side[NQ][1] ? -qx : qx);
      res_y    <= len_zero ? '0 : (dv_side[NQ][0] ? -qy : qy);
      res_len  <= len_t'(dv_len[NQ]);
      res_zero <= len_zero;
    end
  end

  // Skid register holds a stalled result
  unit_t skid_x, skid_y;
  len_t  skid_len;
  logic  skid_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (vec_out.ready) begin
        skid_v <= 1'b0;
      end
    end else if (vld[NSTG-1] && !vec_out.ready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      skid_x    <= res_x;
      skid_y    <= res_y;
      skid_len  <= res_len;
      skid_zero <= res_zero;
    end
  end

  assign vec_out.valid    = skid_v || vld[NSTG-1];
  assign vec_out.norm_x   = skid_v ? skid_x : res_x;
  assign vec_out.norm_y   = skid_v ? skid_y : res_y;
  assign vec_out.length   = skid_v ? skid_len : res_len;
  assign vec_out.was_zero = skid_v ? skid_zero : res_zero;

  // Checks
  `VN_ASSERT(a_zero_clean, vec_out.valid && vec_out.was_zero |-> vec_out.length == '0 && vec_out.norm_x == '0 && vec_out.norm_y == '0, "zero vector beat not cleared")
  `VN_ASSERT(a_unit_range, vec_out.valid |-> vec_out.norm_x <= UNIT_ONE && vec_out.norm_x >= -UNIT_ONE && vec_out.norm_y <= UNIT_ONE && vec_out.norm_y >= -UNIT_ONE, "unit component out of range")
  `VN_ASSERT(a_skid_cause, $rose(skid_v) |-> $past(vld[NSTG-1] && !vec_out.ready), "skid filled without a stalled result")
  `VN_ASSERT_ANY(a_reset_empty, $past(rst) |-> !vec_out.valid && vec_in.ready, "pipeline not empty after reset")

endmodule

FILE: src/vnorm_sqrt_cell.sv
// One root bit of the digit-by-digit integer square root.
module vnorm_sqrt_cell
  import vnorm_pkg::*;
#(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned STEP   = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2*WIDTH-1:0]   rem_in,
  input  logic [2*WIDTH-1:0]   root_in,
  input  logic [SIDE_W-1:0]    side_in,
  output logic [2*WIDTH-1:0]   rem,
  output logic [2*WIDTH-1:0]   root,
  output logic [SIDE_W-1:0]    side
);

  localparam int unsigned NW = 2 * WIDTH;
  localparam logic [NW-1:0] STEP_BIT = {{(NW-1){1'b0}}, 1'b1} << (2 * STEP);

  logic [NW-1:0] trial;
  logic          take;
  logic [NW-1:0] rem_next;
  logic [NW-1:0] root_next;

  // Try to set this root bit
  always_comb begin
    trial     = root_in + STEP_BIT;
    take      = (rem_in >= trial);
    rem_next  = take ? (rem_in - trial) : rem_in;
    root_next = take ? ((root_in >> 1) + STEP_BIT) : (root_in >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      root <= root_next;
      side <= side_in;
    end
  end

endmodule

FILE: src/vnorm_div_cell.sv
// One quotient bit of the restoring division, x and y lanes side by side.
module vnorm_div_cell
  import vnorm_pkg::*;
#(
  parameter int unsigned WIDTH  = 16,
  parameter bit          SHIFT  = 1'b1,
  parameter int unsigned SIDE_W = 2
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [1:0][WIDTH-1:0]          rem_in,
  input  logic [1:0][QUOT_BITS-1:0]      quot_in,
  input  logic [WIDTH-1:0]               len_in,
  input  logic [SIDE_W-1:0]              side_in,
  output logic [1:0][WIDTH-1:0]          rem,
  output logic [1:0][QUOT_BITS-1:0]      quot,
  output logic [WIDTH-1:0]               len,
  output logic [SIDE_W-1:0]              side
);

  logic [1:0][WIDTH:0]           part;
  logic [1:0]                    take;
  logic [1:0][WIDTH:0]           diff;
  logic [1:0][WIDTH-1:0]         rem_next;
  logic [1:0][QUOT_BITS-1:0]     quot_next;

  // Bring down a zero bit when SHIFT is set, then compare against the length
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      part[l]      = SHIFT ? {rem_in[l], 1'b0} : {1'b0, rem_in[l]};
      take[l]      = (part[l] >= {1'b0, len_in});
      diff[l]      = part[l] - {1'b0, len_in};
      rem_next[l]  = take[l] ? diff[l][WIDTH-1:0] : part[l][WIDTH-1:0];
      quot_next[l] = {quot_in[l][QUOT_BITS-2:0], take[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      quot <= quot_next;
      len  <= len_in;
      side <= side_in;
    end
  end

endmodule
